// ----- src/cmot_pkg.sv -----
// Package for the component min online tracker: widths, commands, controller types.
// No dependencies.
`default_nettype none
package cmot_pkg;
    localparam int MAX_STATIONS_DEF = 1024;
    localparam int ID_W = 10;

    localparam logic [1:0] CMD_CONNECT = 2'd0;
    localparam logic [1:0] CMD_QUERY   = 2'd1;
    localparam logic [1:0] CMD_OFFLINE = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Which address the datapath drives to the memories this cycle.
    typedef enum logic [2:0] {
        ASEL_WALK = 3'd0,
        ASEL_COMP = 3'd1,
        ASEL_ROOT = 3'd2,
        ASEL_SCAN = 3'd3,
        ASEL_A    = 3'd4,
        ASEL_RA   = 3'd5
    } asel_t;

    typedef struct packed {
        logic  load;
        logic  mem_rd;
        asel_t asel;
        logic  walk_from_a;
        logic  walk_from_b;
        logic  walk_from_scan;
        logic  walk_step;
        logic  comp_from_a;
        logic  comp_from_b;
        logic  comp_from_scan;
        logic  comp_step;
        logic  save_ra;
        logic  save_root;
        logic  link_wr;
        logic  cursor_clear;
        logic  cursor_rd;
        logic  cursor_load;
        logic  cursor_wr;
        logic  scan_step;
        logic  off_wr;
        logic  compress_wr;
        logic  clr_step;
        logic  emit;
        logic  emit_self;
        logic  emit_none;
        logic  emit_bad;
    } ctl_t;

    typedef struct packed {
        logic       bad;
        logic [1:0] cmd;
        logic       walk_done;
        logic       comp_done;
        logic       roots_equal;
        logic       a_offline;
        logic       scan_over;
        logic       scan_hit_off;
        logic       scan_root_eq;
        logic       clr_done;
    } sts_t;
endpackage
`default_nettype wire

// ----- src/cmot_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module cmot_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- src/cmot_datapath.sv -----
// Datapath: parent, offline and cursor memories, walk/compress/scan registers.
// Depends on cmot_pkg and cmot_ram.
`default_nettype none
module cmot_datapath #(
    parameter int MAX_STATIONS = cmot_pkg::MAX_STATIONS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [cmot_pkg::ID_W-1:0] station_count,
    input  wire logic [1:0]               command,
    input  wire logic [cmot_pkg::ID_W-1:0] node_a,
    input  wire logic [cmot_pkg::ID_W-1:0] node_b,
    input  wire cmot_pkg::ctl_t           ctl,
    output cmot_pkg::sts_t                sts,
    output logic                          done,
    output logic [cmot_pkg::ID_W-1:0]     answer_station,
    output logic                          none_online,
    output logic                          bad_request
);
    localparam int AW = $clog2(MAX_STATIONS);
    localparam int W  = cmot_pkg::ID_W;

    logic [1:0]   cmd_reg;
    logic [W-1:0] a_reg, b_reg, n_reg;
    logic [AW-1:0] walk_reg, comp_reg, ra_reg, root_reg;
    logic [W:0]   scan_reg;
    logic [AW:0]  clr_reg;
    logic [AW-1:0] addr;
    logic [AW-1:0] par_q, cur_q_a;
    logic [W-1:0] cur_q;
    logic         off_q;
    logic         par_we, cur_we, off_we;
    logic [AW-1:0] par_wd;
    logic [W-1:0] cur_wd;
    logic         clearing;
    logic [W-1:0] limit;
    logic         bad_a, bad_b;

    assign clearing = !clr_reg[AW];
    assign limit = (MAX_STATIONS - 1 < (1 << W) - 1 && {1'b0, station_count} >
                    (W+1)'(MAX_STATIONS - 1)) ? W'(MAX_STATIONS - 1) : station_count;

    always_comb
    begin
        unique case (ctl.asel)
            cmot_pkg::ASEL_WALK: addr = walk_reg;
            cmot_pkg::ASEL_COMP: addr = comp_reg;
            cmot_pkg::ASEL_ROOT: addr = root_reg;
            cmot_pkg::ASEL_SCAN: addr = AW'(scan_reg);
            cmot_pkg::ASEL_A:    addr = AW'(a_reg);
            cmot_pkg::ASEL_RA:   addr = ra_reg;
            default:             addr = walk_reg;
        endcase
        if (clearing)
        begin
            addr = clr_reg[AW-1:0];
        end
    end

    assign par_we = clearing || ctl.link_wr || ctl.compress_wr;
    assign par_wd = clearing ? clr_reg[AW-1:0] : (ctl.link_wr ? ra_reg : root_reg);
    assign cur_we = clearing || ctl.cursor_clear || ctl.cursor_wr;
    assign cur_wd = (clearing || ctl.cursor_clear) ? '0 : W'(scan_reg);
    assign off_we = clearing || ctl.off_wr;

    cmot_ram #(.WIDTH(AW), .DEPTH(MAX_STATIONS)) u_parent (
        .clk(clk), .we(par_we), .addr(addr), .wdata(par_wd), .rdata(par_q));
    cmot_ram #(.WIDTH(W), .DEPTH(MAX_STATIONS)) u_cursor (
        .clk(clk), .we(cur_we), .addr(addr), .wdata(cur_wd), .rdata(cur_q));
    cmot_ram #(.WIDTH(1), .DEPTH(MAX_STATIONS)) u_offline (
        .clk(clk), .we(off_we), .addr(addr), .wdata(!clearing), .rdata(off_q));
    assign cur_q_a = AW'(cur_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= command;
            a_reg   <= node_a;
            b_reg   <= node_b;
            n_reg   <= limit;
        end
        if (ctl.walk_from_a) walk_reg <= AW'(a_reg);
        if (ctl.walk_from_b) walk_reg <= AW'(b_reg);
        if (ctl.walk_from_scan) walk_reg <= AW'(scan_reg);
        if (ctl.walk_step)   walk_reg <= par_q;
        if (ctl.comp_from_a) comp_reg <= AW'(a_reg);
        if (ctl.comp_from_b) comp_reg <= AW'(b_reg);
        if (ctl.comp_from_scan) comp_reg <= AW'(scan_reg);
        if (ctl.comp_step)   comp_reg <= par_q;
        if (ctl.save_ra)     ra_reg <= walk_reg;
        if (ctl.save_root)   root_reg <= walk_reg;
        if (ctl.cursor_load) scan_reg <= (cur_q == '0) ? (W+1)'(1) : {1'b0, cur_q};
        if (ctl.scan_step)   scan_reg <= scan_reg + 1'b1;
    end

    // Address bits above the id width never appear: ids are W bits.
    assign bad_a = (a_reg == '0) || (a_reg > n_reg);
    assign bad_b = (b_reg == '0) || (b_reg > n_reg);

    // ra_reg holds the root of a during a connect and the query root during a scan.
    always_comb
    begin
        sts.bad          = bad_a || (cmd_reg == cmot_pkg::CMD_CONNECT && bad_b);
        sts.cmd          = cmd_reg;
        sts.walk_done    = (par_q == walk_reg);
        sts.comp_done    = (comp_reg == root_reg);
        sts.roots_equal  = (ra_reg == walk_reg);
        sts.a_offline    = off_q;
        sts.scan_over    = (scan_reg > {1'b0, n_reg});
        sts.scan_hit_off = off_q;
        sts.scan_root_eq = (walk_reg == ra_reg);
        sts.clr_done     = !clearing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            answer_station <= ctl.emit_self ? a_reg :
                              ((ctl.emit_none || ctl.emit_bad) ? '0 : W'(scan_reg));
            none_online    <= ctl.emit_none;
            bad_request    <= ctl.emit_bad;
        end
    end

    logic unused;
    assign unused = ^{cur_q_a, ctl.mem_rd, ctl.cursor_rd, sts.cmd == cmot_pkg::CMD_NONE};
endmodule
`default_nettype wire

// ----- src/cmot_ctrl.sv -----
// Controller: sequences find, link, compress, offline and scan steps.
// Depends on cmot_pkg.
`default_nettype none
module cmot_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     command,
    input  wire cmot_pkg::sts_t sts,
    output logic                busy,
    output cmot_pkg::ctl_t      ctl
);
    typedef enum logic [15:0] {
        S_CLEAR  = 16'b0000000000000001,
        S_IDLE   = 16'b0000000000000010,
        S_CHECK  = 16'b0000000000000100,
        S_WRD    = 16'b0000000000001000,
        S_WCHK   = 16'b0000000000010000,
        S_CRD    = 16'b0000000000100000,
        S_CCHK   = 16'b0000000001000000,
        S_LINK   = 16'b0000000010000000,
        S_OFFRD  = 16'b0000000100000000,
        S_OFFCHK = 16'b0000001000000000,
        S_CURRD  = 16'b0000010000000000,
        S_CURLD  = 16'b0000100000000000,
        S_SRD    = 16'b0001000000000000,
        S_SCHK   = 16'b0010000000000000,
        S_SFOUND = 16'b0100000000000000,
        S_CCLR   = 16'b1000000000000000
    } state_t;

    // Find purpose: 0 root of a, 1 root of b, 2 query root, 3 scan candidate root.
    typedef enum logic [1:0] {
        F_A = 2'd0, F_B = 2'd1, F_Q = 2'd2, F_S = 2'd3
    } find_t;

    state_t state_reg, state_next;
    find_t  find_reg, find_next;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            find_reg  <= F_A;
        end
        else
        begin
            state_reg <= state_next;
            find_reg  <= find_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        find_next  = find_reg;
        ctl = '0;
        ctl.asel = cmot_pkg::ASEL_WALK;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start && command != cmot_pkg::CMD_NONE)
                begin
                    ctl.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.bad)
                begin
                    ctl.emit = 1'b1;
                    ctl.emit_bad = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.cmd == cmot_pkg::CMD_CONNECT)
                begin
                    ctl.walk_from_a = 1'b1;
                    ctl.comp_from_a = 1'b1;
                    find_next = F_A;
                    state_next = S_WRD;
                end
                else if (sts.cmd == cmot_pkg::CMD_OFFLINE)
                begin
                    ctl.asel = cmot_pkg::ASEL_A;
                    ctl.off_wr = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_OFFRD;
                end
            end
            S_OFFRD:
            begin
                ctl.asel = cmot_pkg::ASEL_A;
                state_next = S_OFFCHK;
            end
            S_OFFCHK:
            begin
                if (!sts.a_offline)
                begin
                    ctl.emit = 1'b1;
                    ctl.emit_self = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.walk_from_a = 1'b1;
                    ctl.comp_from_a = 1'b1;
                    find_next = F_Q;
                    state_next = S_WRD;
                end
            end
            S_WRD:
            begin
                ctl.asel = cmot_pkg::ASEL_WALK;
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                ctl.asel = cmot_pkg::ASEL_WALK;
                if (sts.walk_done)
                begin
                    ctl.save_root = 1'b1;
                    state_next = S_CRD;
                end
                else
                begin
                    ctl.walk_step = 1'b1;
                    state_next = S_WRD;
                end
            end
            S_CRD:
            begin
                ctl.asel = cmot_pkg::ASEL_COMP;
                if (sts.comp_done)
                begin
                    unique case (find_reg)
                        F_A:
                        begin
                            ctl.save_ra = 1'b1;
                            ctl.walk_from_b = 1'b1;
                            ctl.comp_from_b = 1'b1;
                            find_next = F_B;
                            state_next = S_WRD;
                        end
                        F_B: state_next = S_LINK;
                        F_Q:
                        begin
                            // Keep the query root while candidate finds reuse root_reg.
                            ctl.save_ra = 1'b1;
                            state_next = S_CURRD;
                        end
                        F_S: state_next = S_SFOUND;
                        default: state_next = S_IDLE;
                    endcase
                end
                else
                begin
                    state_next = S_CCHK;
                end
            end
            S_CCHK:
            begin
                // Read data holds comp's parent; point comp at root and follow.
                ctl.asel = cmot_pkg::ASEL_COMP;
                ctl.compress_wr = 1'b1;
                ctl.comp_step = 1'b1;
                state_next = S_CRD;
            end
            S_LINK:
            begin
                ctl.asel = cmot_pkg::ASEL_ROOT;
                if (!sts.roots_equal)
                begin
                    ctl.link_wr = 1'b1;
                    state_next = S_CCLR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CCLR:
            begin
                // Restart the surviving root's scan at the first station.
                ctl.asel = cmot_pkg::ASEL_RA;
                ctl.cursor_clear = 1'b1;
                state_next = S_IDLE;
            end
            S_CURRD:
            begin
                ctl.asel = cmot_pkg::ASEL_ROOT;
                state_next = S_CURLD;
            end
            S_CURLD:
            begin
                ctl.cursor_load = 1'b1;
                state_next = S_SRD;
            end
            S_SRD:
            begin
                ctl.asel = cmot_pkg::ASEL_SCAN;
                if (sts.scan_over)
                begin
                    ctl.asel = cmot_pkg::ASEL_RA;
                    ctl.cursor_wr = 1'b1;
                    ctl.emit = 1'b1;
                    ctl.emit_none = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                ctl.asel = cmot_pkg::ASEL_SCAN;
                if (sts.scan_hit_off)
                begin
                    ctl.scan_step = 1'b1;
                    state_next = S_SRD;
                end
                else
                begin
                    ctl.walk_from_scan = 1'b1;
                    find_next = F_S;
                    state_next = S_WRD;
                    ctl.comp_from_scan = 1'b1;
                end
            end
            S_SFOUND:
            begin
                ctl.asel = cmot_pkg::ASEL_ROOT;
                if (sts.scan_root_eq)
                begin
                    ctl.cursor_wr = 1'b1;
                    ctl.emit = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                    state_next = S_SRD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- src/component_min_online_tracker_top.sv -----
// Top level of the component min online tracker: controller plus datapath.
// Depends on cmot_pkg, cmot_ctrl, cmot_datapath, cmot_ram.
//
//  channel | ports                                    | handshake
//  --------+------------------------------------------+----------------------
//  input   | command, node_a, node_b                  | start && !busy
//  result  | answer_station, none_online, bad_request | done, one cycle
//  config  | cfg_we, cfg_data (station_count)         | cfg_we
//
// After reset the memories are cleared one entry a cycle, with busy high. A bad
// id or an offline drops busy from the check state, an online query after the
// offline bit of a is read; a result beat sits on the ports in the first cycle
// with busy low. A connect walks each find with a read and a check state per
// link plus a read and a write state per compressed link, and a merge adds a
// state to clear the surviving root's cursor; an offline query adds the root
// find, then a read and a check state per scanned id plus a find for each online
// candidate. The single port of each memory sets this. Results cannot be stalled.
`default_nettype none
module component_min_online_tracker_top #(
    parameter int MAX_STATIONS = cmot_pkg::MAX_STATIONS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                command,
    input  wire logic [cmot_pkg::ID_W-1:0] node_a,
    input  wire logic [cmot_pkg::ID_W-1:0] node_b,
    output logic                           done,
    output logic [cmot_pkg::ID_W-1:0]      answer_station,
    output logic                           none_online,
    output logic                           bad_request,
    input  wire logic                      cfg_we,
    input  wire logic [cmot_pkg::ID_W-1:0] cfg_data
);
    cmot_pkg::ctl_t ctl;
    cmot_pkg::sts_t sts;
    logic [cmot_pkg::ID_W-1:0] count_reg;

    // Hold station_count; the datapath samples it when a beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= cmot_pkg::ID_W'(1023);
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    cmot_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .sts(sts), .busy(busy), .ctl(ctl));

    cmot_datapath #(.MAX_STATIONS(MAX_STATIONS)) u_dp (
        .clk(clk), .rst_n(rst_n), .station_count(count_reg),
        .command(command), .node_a(node_a), .node_b(node_b),
        .ctl(ctl), .sts(sts), .done(done), .answer_station(answer_station),
        .none_online(none_online), .bad_request(bad_request));

    // A result never carries both flags, a flagged result has answer zero, and an accepted beat raises busy.
    a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(none_online && bad_request)) else $error("two flags");
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (bad_request || none_online) |-> answer_station == '0)
        else $error("answer not zero");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command != cmot_pkg::CMD_NONE |=> busy)
        else $error("no busy after accept");
endmodule
`default_nettype wire

// ----- bench/component_min_online_tracker_top_tb.sv -----
// Self-checking bench for component_min_online_tracker_top: union-find station tracker.
// Depends on cmot_pkg and the RTL of the block; a built-in predictor checks each result beat.
`default_nettype none
module component_min_online_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTA = cmot_pkg::MAX_STATIONS_DEF;
    localparam int ID_W = cmot_pkg::ID_W;
    localparam logic [1:0] CMD_CONNECT = cmot_pkg::CMD_CONNECT;
    localparam logic [1:0] CMD_QUERY   = cmot_pkg::CMD_QUERY;
    localparam logic [1:0] CMD_OFFLINE = cmot_pkg::CMD_OFFLINE;
    localparam logic [1:0] CMD_NONE    = cmot_pkg::CMD_NONE;
    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
    } station_req_t;

    typedef struct packed {
        logic [ID_W-1:0] station;
        logic            none;
        logic            bad;
    } station_ans_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic [1:0]      command;
    logic [ID_W-1:0] node_a;
    logic [ID_W-1:0] node_b;
    logic            done;
    logic [ID_W-1:0] answer_station;
    logic            none_online;
    logic            bad_request;
    logic            cfg_we;
    logic [ID_W-1:0] cfg_data;

    component_min_online_tracker_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .node_a         (node_a),
        .node_b         (node_b),
        .done           (done),
        .answer_station (answer_station),
        .none_online    (none_online),
        .bad_request    (bad_request),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data)
    );

    // Predictor state: a private copy of the station tables.
    int unsigned    link_tab   [NSTA];
    bit             down_tab   [NSTA];
    int unsigned    scan_pos   [NSTA];
    int unsigned    stations_in_use;

    station_req_t   pending_reqs [$];
    station_ans_t   answers_due  [$];
    int             fail_count;
    int             idle_pct;
    int             quiet_cycles;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Find the root of x and point every link on the path straight at it.
    function automatic int unsigned root_of(input int unsigned x);
        int unsigned r;
        int unsigned nxt;
        int unsigned g;
        r = x;
        g = 0;
        while (link_tab[r] != r && g < NSTA) begin
            r = link_tab[r];
            g++;
        end
        g = 0;
        while (x != r && g < NSTA) begin
            nxt = link_tab[x];
            link_tab[x] = r;
            x = nxt;
            g++;
        end
        return r;
    endfunction

    // Advance the tables by one accepted beat and queue the answer, if any.
    function automatic void predict_station_answer(input station_req_t rq);
        int unsigned n;
        int unsigned ra;
        int unsigned rb;
        int unsigned id;
        station_ans_t ans;
        n = (stations_in_use > NSTA - 1) ? NSTA - 1 : stations_in_use;
        ans = '0;
        if (rq.cmd == CMD_NONE)
            return;
        if (rq.a == 0 || rq.a > n || (rq.cmd == CMD_CONNECT && (rq.b == 0 || rq.b > n))) begin
            ans.bad = 1'b1;
            answers_due.push_back(ans);
            return;
        end
        case (rq.cmd)
            CMD_CONNECT:
            begin
                ra = root_of(rq.a);
                rb = root_of(rq.b);
                if (ra != rb) begin
                    link_tab[rb] = ra;
                    scan_pos[ra] = 0;
                end
            end
            CMD_OFFLINE:
                down_tab[rq.a] = 1'b1;
            default:
            begin
                if (!down_tab[rq.a]) begin
                    ans.station = rq.a;
                end else begin
                    ra = root_of(rq.a);
                    id = scan_pos[ra];
                    if (id == 0)
                        id = 1;
                    while (id <= n) begin
                        if (!down_tab[id] && root_of(id) == ra)
                            break;
                        id++;
                    end
                    scan_pos[ra] = id;
                    if (id <= n)
                        ans.station = id[ID_W-1:0];
                    else
                        ans.none = 1'b1;
                end
                answers_due.push_back(ans);
            end
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Driver: present the head of the pending queue, drop it once accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start   <= 1'b0;
            command <= CMD_NONE;
            node_a  <= '0;
            node_b  <= '0;
        end else begin
            if (start && !busy) begin
                predict_station_answer(pending_reqs.pop_front());
            end
            if ((!start || !busy) && (!start || !busy)) begin
                if (start && busy) begin
                    // hold the beat until accepted
                end else if (pending_reqs.size() > 0 &&
                             $urandom_range(99, 0) >= idle_pct) begin
                    start   <= 1'b1;
                    command <= pending_reqs[0].cmd;
                    node_a  <= pending_reqs[0].a;
                    node_b  <= pending_reqs[0].b;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (answers_due.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                station_ans_t exp_ans;
                exp_ans = answers_due.pop_front();
                if (answer_station !== exp_ans.station)
                    report_mismatch($sformatf("answer_station %0d, expected %0d",
                                              answer_station, exp_ans.station));
                if (none_online !== exp_ans.none)
                    report_mismatch($sformatf("none_online %0b, expected %0b",
                                              none_online, exp_ans.none));
                if (bad_request !== exp_ans.bad)
                    report_mismatch($sformatf("bad_request %0b, expected %0b",
                                              bad_request, exp_ans.bad));
            end
        end
    end

    // Watchdog: count cycles with no accepted beat on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("component_min_online_tracker_top_tb: FAIL");
            $finish;
        end
    end

    function automatic station_req_t make_req(input logic [1:0] c, input int unsigned a,
                                              input int unsigned b);
        station_req_t r;
        r.cmd = c;
        r.a   = a[ID_W-1:0];
        r.b   = b[ID_W-1:0];
        return r;
    endfunction

    // Pick a station, mostly in range, sometimes out of range or zero.
    function automatic int unsigned pick_station(input int unsigned n);
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 3)
            return 0;
        if (roll < 6)
            return $urandom_range(1023, 0);
        return $urandom_range(n, 1);
    endfunction

    // Wait until every queued beat went in, every answer came back and
    // a connect or offline with no result has finished.
    task automatic drain_block();
        while (pending_reqs.size() > 0 || answers_due.size() > 0 || start || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_station_count(input int unsigned v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v[ID_W-1:0];
        stations_in_use = v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One random phase: mostly connects early, then offlines and queries.
    task automatic random_phase(input int unsigned n, input int count);
        int unsigned roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99, 0);
            if (i < count / 4 && roll < 70)
                pending_reqs.push_back(make_req(CMD_CONNECT, pick_station(n), pick_station(n)));
            else if (roll < 15)
                pending_reqs.push_back(make_req(CMD_CONNECT, pick_station(n), pick_station(n)));
            else if (roll < 45)
                pending_reqs.push_back(make_req(CMD_OFFLINE, pick_station(n), $urandom_range(1023, 0)));
            else if (roll < 97)
                pending_reqs.push_back(make_req(CMD_QUERY, pick_station(n), $urandom_range(1023, 0)));
            else
                pending_reqs.push_back(make_req(CMD_NONE, $urandom_range(1023, 0),
                                                $urandom_range(1023, 0)));
        end
    endtask

    initial
    begin
        int idle_sel [4];
        int unsigned counts [4];
        idle_sel = '{0, 63, 0, 30};
        counts   = '{40, 12, 1023, 300};
        fail_count = 0;
        idle_pct   = 0;
        stations_in_use = 1023;
        for (int i = 0; i < NSTA; i++) begin
            link_tab[i] = i;
            down_tab[i] = 1'b0;
            scan_pos[i] = 0;
        end
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bad ids at both ends, every command, offline twice,
        // whole component offline, connect after queries, unknown command.
        write_station_count(8);
        pending_reqs.push_back(make_req(CMD_QUERY, 0, 0));
        pending_reqs.push_back(make_req(CMD_QUERY, 9, 0));
        pending_reqs.push_back(make_req(CMD_QUERY, 1023, 1023));
        pending_reqs.push_back(make_req(CMD_CONNECT, 1, 0));
        pending_reqs.push_back(make_req(CMD_CONNECT, 1, 1023));
        pending_reqs.push_back(make_req(CMD_OFFLINE, 0, 5));
        pending_reqs.push_back(make_req(CMD_NONE, 1, 2));
        pending_reqs.push_back(make_req(CMD_CONNECT, 1, 2));
        pending_reqs.push_back(make_req(CMD_CONNECT, 2, 1));
        pending_reqs.push_back(make_req(CMD_CONNECT, 3, 8));
        pending_reqs.push_back(make_req(CMD_QUERY, 8, 0));
        pending_reqs.push_back(make_req(CMD_OFFLINE, 3, 0));
        pending_reqs.push_back(make_req(CMD_OFFLINE, 3, 0));
        pending_reqs.push_back(make_req(CMD_QUERY, 3, 0));
        pending_reqs.push_back(make_req(CMD_OFFLINE, 8, 0));
        pending_reqs.push_back(make_req(CMD_QUERY, 3, 0));
        pending_reqs.push_back(make_req(CMD_CONNECT, 8, 1));
        pending_reqs.push_back(make_req(CMD_QUERY, 3, 0));
        pending_reqs.push_back(make_req(CMD_OFFLINE, 1, 0));
        pending_reqs.push_back(make_req(CMD_OFFLINE, 2, 0));
        pending_reqs.push_back(make_req(CMD_QUERY, 8, 0));
        pending_reqs.push_back(make_req(CMD_QUERY, 7, 0));
        drain_block();

        // Random phases over several counts, the extremes among them.
        for (int p = 0; p < 4; p++) begin
            idle_pct = idle_sel[p];
            write_station_count(counts[p] == 0 ? 1 : counts[p]);
            random_phase(stations_in_use, (p == 2) ? 500 : 340);
            drain_block();
        end
        write_station_count(1);
        random_phase(1, 30);
        drain_block();

        if (fail_count == 0)
            $display("component_min_online_tracker_top_tb: PASS");
        else
            $display("component_min_online_tracker_top_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
